// ===== src/gsl_pkg.sv =====
package gsl_pkg;

   // Fixed-point scaling of angles and of tick lengths.
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int TIME_FRAC_BITS  = 10;

   // One full turn and one half turn in angle units.
   localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
   localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;

   // Range of the biased difference used for the wrap reduction. The bias keeps the
   // value non-negative, so the reduction is a search over a few multiples of a turn.
   localparam int DIFF_MAX   = 65535 + HALF_TURN;
   localparam int BIAS_TURNS = (DIFF_MAX + FULL_TURN - 1) / FULL_TURN;
   localparam int WRAP_MAX   = DIFF_MAX + BIAS_TURNS * FULL_TURN;
   localparam int WRAP_TURNS = WRAP_MAX / FULL_TURN;
   localparam int WRAP_W     = $clog2(WRAP_MAX + 1) + 1;

   // Step limit: rate times elapsed time, scaled down by the time fraction.
   localparam int PROD_W = 32;
   localparam int STEP_W = PROD_W - TIME_FRAC_BITS;
   localparam int LIM_W  = STEP_W + 2;

   // Axis lanes.
   localparam int AXIS_YAW   = 0;
   localparam int AXIS_PITCH = 1;
   localparam int AXIS_ROLL  = 2;
   localparam int NUM_AXES   = 3;

   // Operation codes.
   localparam logic [1:0] OP_VIEW  = 2'd0;
   localparam logic [1:0] OP_ARTIC = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_MAX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_MIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_MAX   = 3'd4;

   localparam logic signed [15:0] PITCH_MIN_RESET = -16'sd5760;
   localparam logic signed [15:0] PITCH_MAX_RESET = 16'sd5760;
   localparam logic signed [15:0] YAW_MIN_RESET   = -16'sd11520;
   localparam logic signed [15:0] YAW_MAX_RESET   = 16'sd11520;

   typedef struct packed {
      logic [1:0]          opcode;
      logic                part_enable;
      logic [2:0]          angle_enable;
      logic signed [15:0]  yaw_in;
      logic signed [15:0]  pitch_in;
      logic signed [15:0]  roll_in;
      logic [15:0]         entity_in;
      logic [2:0]          offset_enable;
      logic signed [15:0]  x_offset_in;
      logic signed [15:0]  y_offset_in;
      logic signed [15:0]  z_offset_in;
      logic [15:0]         elapsed_time;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  yaw_out;
      logic signed [15:0]  pitch_out;
      logic signed [15:0]  roll_out;
      logic [15:0]         view_entity;
      logic signed [15:0]  view_x_offset;
      logic signed [15:0]  view_y_offset;
      logic signed [15:0]  view_z_offset;
   } rsp_type;

   // Limit clamp: below the minimum gives the minimum, otherwise anything not below
   // the maximum gives the maximum. Inverted limits therefore give one of the two.
   function automatic logic signed [15:0] clamp_limit(input logic signed [15:0] x,
                                                      input logic signed [15:0] lo,
                                                      input logic signed [15:0] hi);
      logic signed [15:0] res;
      if (x < lo) begin
         res = lo;
      end else if (x < hi) begin
         res = x;
      end else begin
         res = hi;
      end
      return res;
   endfunction

endpackage

// ===== src/gsl_slew_lane.sv =====
module gsl_slew_lane (
   input  logic signed [15:0]              cur_angle,
   input  logic signed [15:0]              tgt_angle,
   input  logic [gsl_pkg::STEP_W-1:0]      max_step,
   input  logic                            snap,
   output logic signed [15:0]              new_angle
);

   localparam int WW = gsl_pkg::WRAP_W;
   localparam int LW = gsl_pkg::LIM_W;
   localparam logic signed [WW-1:0] WRAP_OFFSET =
      WW'(gsl_pkg::HALF_TURN + gsl_pkg::BIAS_TURNS * gsl_pkg::FULL_TURN);
   localparam logic signed [WW-1:0] HALF_S = WW'(gsl_pkg::HALF_TURN);

   logic signed [WW-1:0] tgt_ext;
   logic signed [WW-1:0] cur_ext;
   logic signed [WW-1:0] biased_s;
   logic [WW-1:0]        biased;
   logic [WW-1:0]        rem;
   logic signed [WW-1:0] wrapped;
   logic signed [LW-1:0] diff_ext;
   logic signed [LW-1:0] step_s;
   logic signed [LW-1:0] limited;
   logic signed [LW-1:0] sum;
   logic signed [15:0]   sat_angle;

   // Biased difference; the bias keeps it non-negative over the whole input range.
   assign tgt_ext  = {{(WW-16){tgt_angle[15]}}, tgt_angle};
   assign cur_ext  = {{(WW-16){cur_angle[15]}}, cur_angle};
   assign biased_s = tgt_ext - cur_ext + WRAP_OFFSET;
   assign biased   = unsigned'(biased_s);

   // Remainder modulo a full turn: take off the largest multiple that fits.
   always_comb begin
      rem = biased;
      for (int k = 1; k <= gsl_pkg::WRAP_TURNS; k++) begin
         if (biased >= WW'(k * gsl_pkg::FULL_TURN)) begin
            rem = biased - WW'(k * gsl_pkg::FULL_TURN);
         end
      end
   end

   // Shortest-path difference in the half-open range of minus to plus half a turn.
   assign wrapped  = signed'(rem) - HALF_S;
   assign diff_ext = {{(LW-WW){wrapped[WW-1]}}, wrapped};
   assign step_s   = signed'({2'b00, max_step});

   // Limit the step to the allowed slew in either direction.
   always_comb begin
      if (diff_ext > step_s) begin
         limited = step_s;
      end else if (diff_ext < -step_s) begin
         limited = -step_s;
      end else begin
         limited = diff_ext;
      end
   end

   // Apply the step and saturate at the field range.
   assign sum = {{(LW-16){cur_angle[15]}}, cur_angle} + limited;

   always_comb begin
      if (sum > LW'(32767)) begin
         sat_angle = 16'sh7FFF;
      end else if (sum < -(LW'(32768))) begin
         sat_angle = -16'sh8000;
      end else begin
         sat_angle = sum[15:0];
      end
   end

   // A zero slew rate snaps straight to the target.
   assign new_angle = snap ? tgt_angle : sat_angle;

endmodule

// ===== src/gsl_out_queue.sv =====
module gsl_out_queue #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  gsl_pkg::rsp_type            push_data,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output gsl_pkg::rsp_type            pop_data,
   output logic [$clog2(DEPTH+1)-1:0]  count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gsl_pkg::rsp_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[head_ff];
   assign count     = count_ff;

   // Pointer and occupancy updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_valid) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

endmodule

// ===== src/gimbal_slew_limiter.sv =====
// Three-axis gimbal angle controller with slew limiting. Every accepted transaction
// gives exactly one result transaction carrying the angles, view entity and view
// offsets after that item. Items pass through two pipeline stages: the first forms
// the step limit (slew_rate times elapsed_time, one 16 x 16 multiplier), the second
// runs three axis lanes side by side (shortest wrapped path, step limit, saturation)
// and merges their outputs with the limit clamps into the stored state. One item is
// taken every cycle while req_ready is high; results wait in an output
// queue of QUEUE_DEPTH entries, and req_ready drops only when that queue plus the
// item in flight would fill it. Configuration writes take effect at the next edge
// and belong to idle periods.
module gimbal_slew_limiter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gsl_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gsl_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [gsl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   logic [15:0]         slew_rate_ff;
   logic signed [15:0]  pitch_min_ff;
   logic signed [15:0]  pitch_max_ff;
   logic signed [15:0]  yaw_min_ff;
   logic signed [15:0]  yaw_max_ff;

   // First stage.
   logic                           a_valid_ff, a_valid_in;
   gsl_pkg::req_type               a_item_ff;
   logic [gsl_pkg::STEP_W-1:0]     a_step_ff;
   logic [gsl_pkg::PROD_W-1:0]     product;

   // Gimbal state.
   logic signed [15:0]  cur_ff [gsl_pkg::NUM_AXES];
   logic signed [15:0]  cur_in [gsl_pkg::NUM_AXES];
   logic [15:0]         entity_ff, entity_in;
   logic signed [15:0]  offset_ff [gsl_pkg::NUM_AXES];
   logic signed [15:0]  offset_in [gsl_pkg::NUM_AXES];
   logic                pend_valid_ff, pend_valid_in;
   logic [2:0]          pend_mask_ff, pend_mask_in;
   logic signed [15:0]  pend_ff [gsl_pkg::NUM_AXES];
   logic signed [15:0]  pend_in [gsl_pkg::NUM_AXES];

   // Lane signals.
   logic signed [15:0]  lane_tgt [gsl_pkg::NUM_AXES];
   logic signed [15:0]  lane_out [gsl_pkg::NUM_AXES];
   logic signed [15:0]  item_angle [gsl_pkg::NUM_AXES];
   logic signed [15:0]  item_offset [gsl_pkg::NUM_AXES];

   gsl_pkg::rsp_type    result;
   logic [CNT_W-1:0]    q_count;
   logic [CNT_W:0]      occupancy;
   logic                req_fire;

   // Configuration write port.
   always_ff @(posedge clock) begin
      if (reset) begin
         slew_rate_ff <= '0;
         pitch_min_ff <= gsl_pkg::PITCH_MIN_RESET;
         pitch_max_ff <= gsl_pkg::PITCH_MAX_RESET;
         yaw_min_ff   <= gsl_pkg::YAW_MIN_RESET;
         yaw_max_ff   <= gsl_pkg::YAW_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gsl_pkg::CSR_SLEW_RATE: slew_rate_ff <= csr_wdata;
            gsl_pkg::CSR_PITCH_MIN: pitch_min_ff <= signed'(csr_wdata);
            gsl_pkg::CSR_PITCH_MAX: pitch_max_ff <= signed'(csr_wdata);
            gsl_pkg::CSR_YAW_MIN:   yaw_min_ff   <= signed'(csr_wdata);
            gsl_pkg::CSR_YAW_MAX:   yaw_max_ff   <= signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Accept while the queue has room for this item and the one in flight.
   assign occupancy = {1'b0, q_count} + {{CNT_W{1'b0}}, a_valid_ff};
   assign req_ready = (occupancy < (CNT_W + 1)'(QUEUE_DEPTH));
   assign req_fire  = req_valid && req_ready;

   // First stage: capture the item and form the step limit.
   assign product    = gsl_pkg::PROD_W'(req_data.elapsed_time) *
                       gsl_pkg::PROD_W'(slew_rate_ff);
   assign a_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_item_ff <= req_data;
         a_step_ff <= product[gsl_pkg::PROD_W-1:gsl_pkg::TIME_FRAC_BITS];
      end
   end

   // Item fields by axis.
   assign item_angle[gsl_pkg::AXIS_YAW]   = a_item_ff.yaw_in;
   assign item_angle[gsl_pkg::AXIS_PITCH] = a_item_ff.pitch_in;
   assign item_angle[gsl_pkg::AXIS_ROLL]  = a_item_ff.roll_in;
   assign item_offset[0] = a_item_ff.x_offset_in;
   assign item_offset[1] = a_item_ff.y_offset_in;
   assign item_offset[2] = a_item_ff.z_offset_in;

   // Axis lanes: an axis without a pending target aims at its current angle.
   for (genvar g = 0; g < gsl_pkg::NUM_AXES; g++) begin : g_lane
      assign lane_tgt[g] = pend_mask_ff[g] ? pend_ff[g] : cur_ff[g];

      gsl_slew_lane u_lane (
         .cur_angle (cur_ff[g]),
         .tgt_angle (lane_tgt[g]),
         .max_step  (a_step_ff),
         .snap      (slew_rate_ff == '0),
         .new_angle (lane_out[g])
      );
   end

   // Second stage: merge the lanes into the next state.
   always_comb begin
      cur_in        = cur_ff;
      entity_in     = entity_ff;
      offset_in     = offset_ff;
      pend_valid_in = pend_valid_ff;
      pend_mask_in  = pend_mask_ff;
      pend_in       = pend_ff;
      unique case (a_item_ff.opcode)
         gsl_pkg::OP_VIEW: begin
            for (int i = 0; i < gsl_pkg::NUM_AXES; i++) begin
               if (a_item_ff.angle_enable[i]) begin
                  cur_in[i] = item_angle[i];
               end
            end
            cur_in[gsl_pkg::AXIS_PITCH] = gsl_pkg::clamp_limit(
               cur_in[gsl_pkg::AXIS_PITCH], pitch_min_ff, pitch_max_ff);
            cur_in[gsl_pkg::AXIS_YAW] = gsl_pkg::clamp_limit(
               cur_in[gsl_pkg::AXIS_YAW], yaw_min_ff, yaw_max_ff);
            entity_in = a_item_ff.entity_in;
            for (int i = 0; i < gsl_pkg::NUM_AXES; i++) begin
               if (a_item_ff.entity_in == '0) begin
                  offset_in[i] = '0;
               end else if (a_item_ff.offset_enable[i]) begin
                  offset_in[i] = item_offset[i];
               end
            end
         end
         gsl_pkg::OP_ARTIC: begin
            if (a_item_ff.part_enable) begin
               pend_valid_in = 1'b1;
               pend_mask_in  = pend_mask_ff | a_item_ff.angle_enable;
               for (int i = 0; i < gsl_pkg::NUM_AXES; i++) begin
                  if (a_item_ff.angle_enable[i]) begin
                     pend_in[i] = item_angle[i];
                  end
               end
            end
         end
         gsl_pkg::OP_TICK: begin
            if (pend_valid_ff) begin
               cur_in[gsl_pkg::AXIS_ROLL]  = lane_out[gsl_pkg::AXIS_ROLL];
               cur_in[gsl_pkg::AXIS_PITCH] = gsl_pkg::clamp_limit(
                  lane_out[gsl_pkg::AXIS_PITCH], pitch_min_ff, pitch_max_ff);
               cur_in[gsl_pkg::AXIS_YAW] = gsl_pkg::clamp_limit(
                  lane_out[gsl_pkg::AXIS_YAW], yaw_min_ff, yaw_max_ff);
               pend_valid_in = 1'b0;
               pend_mask_in  = '0;
               for (int i = 0; i < gsl_pkg::NUM_AXES; i++) begin
                  pend_in[i] = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State registers advance once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         entity_ff     <= '0;
         pend_valid_ff <= 1'b0;
         pend_mask_ff  <= '0;
         for (int i = 0; i < gsl_pkg::NUM_AXES; i++) begin
            cur_ff[i]    <= '0;
            offset_ff[i] <= '0;
            pend_ff[i]   <= '0;
         end
      end else if (a_valid_ff) begin
         entity_ff     <= entity_in;
         pend_valid_ff <= pend_valid_in;
         pend_mask_ff  <= pend_mask_in;
         cur_ff        <= cur_in;
         offset_ff     <= offset_in;
         pend_ff       <= pend_in;
      end
   end

   // Result of the item: the state after it.
   assign result.yaw_out       = cur_in[gsl_pkg::AXIS_YAW];
   assign result.pitch_out     = cur_in[gsl_pkg::AXIS_PITCH];
   assign result.roll_out      = cur_in[gsl_pkg::AXIS_ROLL];
   assign result.view_entity   = entity_in;
   assign result.view_x_offset = offset_in[0];
   assign result.view_y_offset = offset_in[1];
   assign result.view_z_offset = offset_in[2];

   gsl_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (a_valid_ff),
      .push_data  (result),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data),
      .count      (q_count)
   );

`ifndef SYNTHESIS
   // An item reaching the merge stage always finds room in the queue.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (q_count < CNT_W'(QUEUE_DEPTH)))
      else $error("output queue overflow");

   // A tick clears any pending target.
   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_item_ff.opcode == gsl_pkg::OP_TICK)) |=>
      (!pend_valid_ff && (pend_mask_ff == '0)))
      else $error("pending target survived a tick");

   // After a view item, pitch lies within ordered limits.
   a_view_clamp: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_item_ff.opcode == gsl_pkg::OP_VIEW) &&
       (pitch_min_ff <= pitch_max_ff)) |=>
      ((cur_ff[gsl_pkg::AXIS_PITCH] >= $past(pitch_min_ff)) &&
       (cur_ff[gsl_pkg::AXIS_PITCH] <= $past(pitch_max_ff))))
      else $error("pitch outside its limits after a view item");

   // A view with entity zero leaves all offsets cleared.
   a_view_off: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_item_ff.opcode == gsl_pkg::OP_VIEW) &&
       (a_item_ff.entity_in == '0)) |=>
      ((entity_ff == '0) && (offset_ff[0] == '0) && (offset_ff[1] == '0) &&
       (offset_ff[2] == '0)))
      else $error("view offsets kept after the view was cleared");
`endif

endmodule
